// ===== rtl/windowed_channel_histogram_macros.svh =====
// ---------------------------------------------------------------------------
// Windowed channel histogram - assertion macros
// Shared concurrent check forms for the histogram RTL.
// ---------------------------------------------------------------------------
`ifndef WINDOWED_CHANNEL_HISTOGRAM_MACROS_SVH
`define WINDOWED_CHANNEL_HISTOGRAM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WCH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("windowed_channel_histogram: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("windowed_channel_histogram: next-cycle check failed");

`endif

// ===== rtl/wch_pkg.sv =====
// ---------------------------------------------------------------------------
// Windowed channel histogram - package
// Request codes, register indexes and stream field layout.
// ---------------------------------------------------------------------------
`default_nettype none

package wch_pkg;

    // Request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_READ  = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_START       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SPAN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_TRANSPARENT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_UNSELECTED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_USED    = 3'd4;
    localparam int CFG_DATA_W = 16;
    localparam int CHAN_CFG_W = 3;

    // Stream layout
    localparam int VALUE_W     = 16;
    localparam int IN_CHANNELS = 4;
    localparam int OUT_W       = 32;
    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 128;
    localparam int SEL_BIT     = 64;
    localparam int TRANSP_BIT  = 65;
    localparam int RD_CH_LSB   = 66;
    localparam int RD_CH_W     = 2;
    localparam int RD_BIN_LSB  = 68;
    localparam int RD_BIN_W    = 8;

endpackage

`default_nettype wire

// ===== rtl/windowed_channel_histogram.sv =====
// ---------------------------------------------------------------------------
// Windowed channel histogram
// Per-channel histogram over a programmable 16-bit value window, with below,
// above and pixel-total counters, read-back and clear requests.
// ---------------------------------------------------------------------------
// Each request returns one result transfer. Bin counts live in one
// synchronous RAM of NUM_CHANNELS * 2^clog2(NUM_BINS) words; below/above and
// pixel-total counters are flops. An add request runs a multiply step, one
// restoring-division step per bin-index bit (all lanes divide in parallel),
// then one read-modify-write slot per input lane (min(NUM_CHANNELS,4) lanes)
// on the bin RAM. A read request passes through a RAM read state before its
// response; an unknown request goes straight to the response. A clear
// request, and reset, sweep the RAM one word per cycle, during which no
// input is accepted; configuration writes are taken at any time. All
// counters saturate; outputs show 0xFFFFFFFF for counts that do not fit.
`default_nettype none

`include "windowed_channel_histogram_macros.svh"

module windowed_channel_histogram #(
    parameter int NUM_CHANNELS = 4,
    parameter int NUM_BINS     = 256,
    parameter int COUNT_BITS   = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // config write port
    input  wire logic                                cfg_we,
    input  wire logic [wch_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [wch_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // request stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // chan0_value, chan1_value, chan2_value, chan3_value, is_selected,
    // is_transparent, read_channel, read_bin, zero pad
    input  wire logic [wch_pkg::S_TDATA_W-1:0]       s_tdata,
    // req_type
    input  wire logic [wch_pkg::S_TUSER_W-1:0]       s_tuser,
    input  wire logic                                s_tlast,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // bin_count, below_count, above_count, pixel_total
    output logic [wch_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic                                     m_tlast
);

    localparam int LANES  = (NUM_CHANNELS < wch_pkg::IN_CHANNELS) ?
                            NUM_CHANNELS : wch_pkg::IN_CHANNELS;
    localparam int LW     = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int DEPTH  = NUM_CHANNELS * (1 << BIN_W);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = wch_pkg::VALUE_W + BIN_W;
    localparam int DCNT_W = $clog2(BIN_W);
    localparam int VW     = wch_pkg::VALUE_W;

    typedef enum logic [6:0] {
        S_SWEEP = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_RMW   = 7'b0010000,
        S_READ  = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    typedef logic [COUNT_BITS-1:0] count_t;

    function automatic count_t sat_inc(input count_t c);
        return (c == '1) ? c : c + COUNT_BITS'(1);
    endfunction

    function automatic logic [wch_pkg::OUT_W-1:0] out32(input count_t c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [2:0] ch,
                                                   input logic [BIN_W-1:0] b);
        return ADDR_W'((32'(ch) << BIN_W) | 32'(b));
    endfunction

    // ---------------- configuration ----------------
    logic [VW-1:0]                   view_start_reg;
    logic [VW-1:0]                   view_span_reg;
    logic                            skip_transp_reg;
    logic                            skip_unsel_reg;
    logic [wch_pkg::CHAN_CFG_W-1:0]  chan_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_start_reg  <= '0;
            view_span_reg   <= 16'hFFFF;
            skip_transp_reg <= 1'b0;
            skip_unsel_reg  <= 1'b0;
            chan_used_reg   <= 3'd4;
        end else if (cfg_we) begin
            case (cfg_index)
                wch_pkg::CFG_VIEW_START:       view_start_reg  <= cfg_wdata;
                wch_pkg::CFG_VIEW_SPAN:        view_span_reg   <= cfg_wdata;
                wch_pkg::CFG_SKIP_TRANSPARENT: skip_transp_reg <= cfg_wdata[0];
                wch_pkg::CFG_SKIP_UNSELECTED:  skip_unsel_reg  <= cfg_wdata[0];
                wch_pkg::CFG_CHANNELS_USED:
                    chan_used_reg <= cfg_wdata[wch_pkg::CHAN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input unpack and classification ----------------
    logic                          s_xfer;
    logic [1:0]                    in_req;
    logic                          in_sel;
    logic                          in_transp;
    logic [wch_pkg::RD_CH_W-1:0]   in_rd_ch;
    logic [wch_pkg::RD_BIN_W-1:0]  in_rd_bin;
    logic                          in_skip;
    logic [VW:0]                   win_sum;
    logic [VW-1:0]                 win_end;
    logic [2:0]                    n_eff;
    logic [VW-1:0]                 lane_val   [LANES];
    logic                          lane_act   [LANES];
    logic                          lane_above [LANES];
    logic                          lane_below [LANES];
    logic [VW-1:0]                 lane_diff  [LANES];
    logic                          rd_ch_ok;

    state_t state_reg;
    state_t state_next;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign in_req    = s_tuser;
    assign in_sel    = s_tdata[wch_pkg::SEL_BIT];
    assign in_transp = s_tdata[wch_pkg::TRANSP_BIT];
    assign in_rd_ch  = s_tdata[wch_pkg::RD_CH_LSB +: wch_pkg::RD_CH_W];
    assign in_rd_bin = s_tdata[wch_pkg::RD_BIN_LSB +: wch_pkg::RD_BIN_W];
    assign in_skip   = (skip_unsel_reg && !in_sel) || (skip_transp_reg && in_transp);
    assign rd_ch_ok  = 32'(in_rd_ch) < NUM_CHANNELS;

    // window end saturates at full scale
    assign win_sum = {1'b0, view_start_reg} + {1'b0, view_span_reg};
    assign win_end = win_sum[VW] ? '1 : win_sum[VW-1:0];

    always_comb begin
        if (chan_used_reg == '0) begin
            n_eff = 3'd1;
        end else if (chan_used_reg > 3'(LANES)) begin
            n_eff = 3'(LANES);
        end else begin
            n_eff = chan_used_reg;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane_cls
        assign lane_val[l]   = s_tdata[l*VW +: VW];
        assign lane_act[l]   = 3'(l) < n_eff;
        assign lane_above[l] = lane_val[l] > win_end;
        assign lane_below[l] = lane_val[l] < view_start_reg;
        assign lane_diff[l]  = lane_val[l] - view_start_reg;
    end

    // ---------------- per-lane divider state ----------------
    logic [VW-1:0]      diff_reg     [LANES];
    logic               need_bin_reg [LANES];
    logic [PROD_W-1:0]  rem_reg      [LANES];
    logic [BIN_W-1:0]   quo_reg      [LANES];
    logic [PROD_W-1:0]  dsor_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;

    // ---------------- RMW sequencing ----------------
    logic [LW:0]        rmw_idx_reg;
    logic [LW-1:0]      lane_sel;
    logic               rmw_live;
    logic [BIN_W-1:0]   lane_bin;
    logic               wr_pend_reg;
    logic [ADDR_W-1:0]  wr_addr_reg;

    assign lane_sel = rmw_idx_reg[LW-1:0];
    assign rmw_live = rmw_idx_reg < (LW+1)'(LANES);

    always_comb begin
        if (view_span_reg == '0) begin
            lane_bin = '0;
        end else if (quo_reg[lane_sel] > BIN_W'(NUM_BINS-1)) begin
            lane_bin = BIN_W'(NUM_BINS-1);
        end else begin
            lane_bin = quo_reg[lane_sel];
        end
    end

    // ---------------- bin memory ----------------
    count_t             mem [DEPTH];
    count_t             rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    count_t             mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [ADDR_W-1:0]  sweep_cnt_reg;
    logic               sweep_resp_reg;
    logic               sweep_last;

    assign sweep_last = sweep_cnt_reg == ADDR_W'(DEPTH-1);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = sat_inc(rd_data_reg);
        if (state_reg == S_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            mem_wdata = '0;
        end else if (state_reg == S_RMW) begin
            mem_we    = wr_pend_reg;
        end
    end

    always_comb begin
        case (state_reg)
            S_IDLE:  mem_raddr = mem_addr(3'(in_rd_ch), in_rd_bin[BIN_W-1:0]);
            S_RMW:   mem_raddr = mem_addr(3'(lane_sel), lane_bin);
            default: mem_raddr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // ---------------- counters ----------------
    count_t below_reg [NUM_CHANNELS];
    count_t above_reg [NUM_CHANNELS];
    count_t pixels_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                below_reg[c] <= '0;
                above_reg[c] <= '0;
            end
            pixels_reg <= '0;
        end else if (s_xfer) begin
            if (in_req == wch_pkg::REQ_CLEAR) begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    below_reg[c] <= '0;
                    above_reg[c] <= '0;
                end
                pixels_reg <= '0;
            end else if (in_req == wch_pkg::REQ_ADD && !in_skip) begin
                for (int l = 0; l < LANES; l++) begin
                    if (lane_act[l] && lane_above[l]) begin
                        above_reg[l] <= sat_inc(above_reg[l]);
                    end else if (lane_act[l] && lane_below[l]) begin
                        below_reg[l] <= sat_inc(below_reg[l]);
                    end
                end
                pixels_reg <= sat_inc(pixels_reg);
            end
        end
    end

    // ---------------- control ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_SWEEP: begin
                if (sweep_last) begin
                    state_next = sweep_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_xfer) begin
                    case (in_req)
                        wch_pkg::REQ_ADD:   state_next = in_skip ? S_RESP : S_MUL;
                        wch_pkg::REQ_READ:  state_next = S_READ;
                        wch_pkg::REQ_CLEAR: state_next = S_SWEEP;
                        default:            state_next = S_RESP;
                    endcase
                end
            end
            S_MUL:  state_next = S_DIV;
            S_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = S_RMW;
                end
            end
            S_RMW: begin
                if (!rmw_live) begin
                    state_next = S_RESP;
                end
            end
            S_READ: state_next = S_RESP;
            S_RESP: begin
                if (!m_tvalid || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SWEEP;
            sweep_cnt_reg  <= '0;
            sweep_resp_reg <= 1'b0;
            div_cnt_reg    <= '0;
            rmw_idx_reg    <= '0;
            wr_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_SWEEP) begin
                sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
            end
            if (s_xfer && in_req == wch_pkg::REQ_CLEAR) begin
                sweep_cnt_reg  <= '0;
                sweep_resp_reg <= 1'b1;
            end
            if (state_reg == S_MUL) begin
                div_cnt_reg <= DCNT_W'(BIN_W-1);
                rmw_idx_reg <= '0;
                wr_pend_reg <= 1'b0;
            end else if (state_reg == S_DIV) begin
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end else if (state_reg == S_RMW) begin
                rmw_idx_reg <= rmw_idx_reg + (LW+1)'(1);
                wr_pend_reg <= rmw_live && need_bin_reg[lane_sel];
            end
            if (m_tvalid && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == S_RESP && (!m_tvalid || m_tready)) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // ---------------- datapath (no reset) ----------------
    count_t  res_bin_reg;
    count_t  res_below_reg;
    count_t  res_above_reg;
    logic    res_done_reg;
    logic    bin_ok_reg;
    logic [wch_pkg::M_TDATA_W-1:0] m_data_reg;
    logic    m_last_reg;

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_bin_reg   <= '0;
            res_below_reg <= '0;
            res_above_reg <= '0;
            res_done_reg  <= (in_req == wch_pkg::REQ_ADD) ? s_tlast : 1'b0;
            bin_ok_reg    <= rd_ch_ok && (32'(in_rd_bin) < NUM_BINS);
            if (in_req == wch_pkg::REQ_READ && rd_ch_ok) begin
                res_below_reg <= below_reg[CH_W'(in_rd_ch)];
                res_above_reg <= above_reg[CH_W'(in_rd_ch)];
            end
            for (int l = 0; l < LANES; l++) begin
                diff_reg[l]     <= lane_diff[l];
                need_bin_reg[l] <= lane_act[l] && !lane_above[l] && !lane_below[l];
            end
        end
        if (state_reg == S_READ) begin
            res_bin_reg <= bin_ok_reg ? rd_data_reg : '0;
        end
        if (state_reg == S_MUL) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[l] <= PROD_W'(diff_reg[l]) * PROD_W'(NUM_BINS-1);
                quo_reg[l] <= '0;
            end
            dsor_reg <= PROD_W'(view_span_reg) << (BIN_W-1);
        end else if (state_reg == S_DIV) begin
            // one restoring step per cycle, quotient bit MSB first
            for (int l = 0; l < LANES; l++) begin
                if (rem_reg[l] >= dsor_reg) begin
                    rem_reg[l] <= rem_reg[l] - dsor_reg;
                    quo_reg[l] <= {quo_reg[l][BIN_W-2:0], 1'b1};
                end else begin
                    quo_reg[l] <= {quo_reg[l][BIN_W-2:0], 1'b0};
                end
            end
            dsor_reg <= dsor_reg >> 1;
        end
        if (state_reg == S_RMW) begin
            wr_addr_reg <= mem_raddr;
        end
        if (state_reg == S_RESP && (!m_tvalid || m_tready)) begin
            m_data_reg <= {out32(pixels_reg), out32(res_above_reg),
                           out32(res_below_reg), out32(res_bin_reg)};
            m_last_reg <= res_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    `WCH_ASSERT_SAME(a_no_write_idle, aclk, aresetn, state_reg == S_IDLE, !mem_we)
    `WCH_ASSERT_SAME(a_result_from_resp, aclk, aresetn, $rose(m_tvalid), $past(state_reg == S_RESP))
    `WCH_ASSERT_NEXT(a_clear_sweeps, aclk, aresetn, s_xfer && in_req == wch_pkg::REQ_CLEAR, state_reg == S_SWEEP && pixels_reg == '0)

endmodule

`default_nettype wire
